/* src/tng_pkg.sv */
// Shared types, codes and character classes for the text tokenizer.
`timescale 1ns / 1ps

package tng_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_MODE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = 1'b1;

	localparam int CFG_DATA_W = 16;

	// Mode codes. Any code other than these two splits on whitespace only.
	localparam logic [1:0] MODE_PUNCT = 2'd0;
	localparam logic [1:0] MODE_NGRAM = 2'd1;

	// Packed result payload width, rounded up to whole bytes.
	localparam int OUT_DATA_W = 56;

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	// What a queued job asks the back end to do.
	typedef struct packed {
		logic has_word;   // a finished word is attached
		logic ngram;      // expand the word into 2-grams and 3-grams
		logic has_close;  // the closing result follows the word
	} job_flags_t;

	function automatic logic is_space(input logic [7:0] b);
		logic r;
		case (b) inside
			CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic is_mark(input logic [7:0] b);
		logic r;
		case (b) inside
			CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_BANG, CH_QUEST,
			CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE,
			CH_RBRACE, CH_DQUOTE, CH_SQUOTE: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

/* src/tng_front.sv */
// Front end: classifies each byte, tracks the current word and queues finished words.
`timescale 1ns / 1ps

module tng_front #(
	parameter int MAX_WORD_CHARS = 32,
	parameter int COUNTER_BITS   = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [1:0]                                mode,
	input  logic                                      in_valid,
	output logic                                      in_ready,
	input  logic [7:0]                                in_byte,
	input  logic                                      in_eot,
	input  logic                                      job_full,
	output logic                                      job_push,
	output tng_pkg::job_flags_t                       job_flags,
	output logic [COUNTER_BITS-1:0]                   job_start,
	output logic [$clog2(MAX_WORD_CHARS)-1:0]         job_len,
	output logic [COUNTER_BITS-1:0]                   job_pos,
	output logic [COUNTER_BITS-1:0]                   job_close_words
);
	import tng_pkg::*;

	localparam int LEN_W = $clog2(MAX_WORD_CHARS);
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
	localparam logic [LEN_W-1:0] CUT_LEN = LEN_W'(MAX_WORD_CHARS - 1);

	logic [COUNTER_BITS-1:0] scan_q;
	logic [COUNTER_BITS-1:0] start_q;
	logic [COUNTER_BITS-1:0] count_q;
	logic [LEN_W-1:0]        len_q;
	logic                    in_word_q;

	logic                    accept;
	logic                    delim;
	logic [LEN_W-1:0]        len_inc;
	logic [COUNTER_BITS-1:0] start_w;
	logic                    cut;
	logic                    finish;
	logic [COUNTER_BITS-1:0] count_inc;
	logic [COUNTER_BITS-1:0] scan_inc;

	assign in_ready = !job_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		delim     = is_space(in_byte) || ((mode == MODE_PUNCT) && is_mark(in_byte));
		len_inc   = in_word_q ? (len_q + LEN_W'(1)) : LEN_W'(1);
		start_w   = in_word_q ? start_q : scan_q;
		cut       = !delim && (len_inc >= CUT_LEN);
		// The end of text closes an open word as well.
		finish    = delim ? in_word_q : (cut || in_eot);
		count_inc = (count_q == CNT_MAX) ? count_q : (count_q + COUNTER_BITS'(1));
		scan_inc  = (scan_q == CNT_MAX) ? scan_q : (scan_q + COUNTER_BITS'(1));
	end

	assign job_push            = accept && (finish || in_eot);
	assign job_flags.has_word  = finish;
	assign job_flags.ngram     = (mode == MODE_NGRAM);
	assign job_flags.has_close = in_eot;
	assign job_start           = start_w;
	assign job_len             = delim ? len_q : len_inc;
	assign job_pos             = count_q;
	assign job_close_words     = finish ? count_inc : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q    <= '0;
			start_q   <= '0;
			count_q   <= '0;
			len_q     <= '0;
			in_word_q <= 1'b0;
		end else if (accept) begin
			if (in_eot) begin
				scan_q    <= '0;
				start_q   <= '0;
				count_q   <= '0;
				len_q     <= '0;
				in_word_q <= 1'b0;
			end else begin
				scan_q <= scan_inc;
				if (finish) begin
					count_q   <= count_inc;
					len_q     <= '0;
					in_word_q <= 1'b0;
				end else if (!delim) begin
					start_q   <= start_w;
					len_q     <= len_inc;
					in_word_q <= 1'b1;
				end
			end
		end
	end

	a_word_has_length: assert property (@(posedge clk) disable iff (!arst_n)
		in_word_q |-> (len_q != '0) && (len_q < CUT_LEN))
		else $error("open word with an impossible length");

	a_idle_length_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!in_word_q |-> (len_q == '0))
		else $error("length left over outside a word");

endmodule

/* src/tng_queue.sv */
// Short first-word-fall-through queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module tng_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             head_valid,
	output logic [WIDTH-1:0] head_data
);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	logic do_push;
	logic do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : (wr_ptr_q + PTR_W'(1));
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : (rd_ptr_q + PTR_W'(1));
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue fill count beyond depth");

endmodule

/* src/tng_back.sv */
// Back end: expands queued jobs into token and closing results, one per cycle unless the output stalls.
`timescale 1ns / 1ps

module tng_back #(
	parameter int MAX_WORD_CHARS = 32,
	parameter int COUNTER_BITS   = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic [15:0]                               token_limit,
	input  logic                                      head_valid,
	input  tng_pkg::job_flags_t                       head_flags,
	input  logic [COUNTER_BITS-1:0]                   head_start,
	input  logic [$clog2(MAX_WORD_CHARS)-1:0]         head_len,
	input  logic [COUNTER_BITS-1:0]                   head_pos,
	input  logic [COUNTER_BITS-1:0]                   head_close_words,
	output logic                                      pop,
	output logic                                      out_valid,
	input  logic                                      out_ready,
	output logic [15:0]                               out_offset,
	output logic [4:0]                                out_length,
	output logic [15:0]                               out_position,
	output logic                                      out_last,
	output logic                                      out_done,
	output logic [15:0]                               out_total
);
	import tng_pkg::*;

	localparam int LEN_W = $clog2(MAX_WORD_CHARS);
	localparam int CW    = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
	localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;
	localparam logic [LEN_W:0] G2 = (LEN_W + 1)'(2);
	localparam logic [LEN_W:0] G3 = (LEN_W + 1)'(3);

	// Job phases: the word's tokens first, then the closing result.
	localparam logic PH_WORD  = 1'b0;
	localparam logic PH_CLOSE = 1'b1;

	function automatic logic [15:0] clamp16(input logic [COUNTER_BITS-1:0] v);
		logic [CW-1:0] w;
		w = CW'(v);
		return (w > CW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
	endfunction

	logic                    phase_q;
	logic                    g3_q;
	logic [LEN_W-1:0]        s_q;
	logic [COUNTER_BITS-1:0] emitted_q;

	logic                    out_valid_q;
	logic [15:0]             out_offset_q;
	logic [4:0]              out_length_q;
	logic [15:0]             out_position_q;
	logic                    out_last_q;
	logic                    out_done_q;
	logic [15:0]             out_total_q;

	logic                    go;
	logic                    limit_ok;
	logic                    limit_ok_next;
	logic [COUNTER_BITS-1:0] emitted_inc;
	logic [LEN_W:0]          gsize;
	logic [LEN_W:0]          sum_s;
	logic                    pos_ok;
	logic                    next_ok;
	logic                    more3;
	logic                    emit_tok;
	logic                    word_over;
	logic [COUNTER_BITS:0]   off_sum;
	logic [COUNTER_BITS-1:0] off_sat;

	logic                    load;
	logic [15:0]             ld_offset;
	logic [4:0]              ld_length;
	logic [15:0]             ld_position;
	logic                    ld_last;
	logic                    ld_done;
	logic [15:0]             ld_total;
	logic                    phase_n;
	logic                    g3_n;
	logic [LEN_W-1:0]        s_n;
	logic [COUNTER_BITS-1:0] emitted_n;

	assign go = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		limit_ok      = CW'(emitted_q) < CW'(token_limit);
		emitted_inc   = (emitted_q == CNT_MAX) ? emitted_q : (emitted_q + COUNTER_BITS'(1));
		limit_ok_next = CW'(emitted_inc) < CW'(token_limit);
		gsize         = g3_q ? G3 : G2;
		sum_s         = {1'b0, s_q} + gsize;
		pos_ok        = sum_s <= {1'b0, head_len};
		next_ok       = (sum_s + (LEN_W + 1)'(1)) <= {1'b0, head_len};
		more3         = !g3_q && ({1'b0, head_len} >= G3);
		off_sum       = {1'b0, head_start} + (COUNTER_BITS + 1)'(s_q);
		off_sat       = off_sum[COUNTER_BITS] ? CNT_MAX : off_sum[COUNTER_BITS-1:0];

		if (head_flags.ngram) begin
			emit_tok  = pos_ok && limit_ok;
			word_over = !emit_tok || !((next_ok || more3) && limit_ok_next);
		end else begin
			emit_tok  = (head_len != '0) && limit_ok;
			word_over = 1'b1;
		end

		load        = 1'b0;
		ld_offset   = clamp16(off_sat);
		ld_length   = head_flags.ngram ? 5'(gsize) : 5'(head_len);
		ld_position = clamp16(head_pos);
		ld_last     = 1'b0;
		ld_done     = 1'b0;
		ld_total    = '0;
		pop         = 1'b0;
		phase_n     = phase_q;
		g3_n        = g3_q;
		s_n         = s_q;
		emitted_n   = emitted_q;

		unique case (phase_q)
			PH_WORD: begin
				if (!head_flags.has_word) begin
					load        = 1'b1;
					ld_offset   = '0;
					ld_length   = '0;
					ld_position = clamp16(head_close_words);
					ld_last     = 1'b1;
					ld_done     = 1'b1;
					ld_total    = clamp16(emitted_q);
					emitted_n   = '0;
					pop         = go;
				end else begin
					if (emit_tok) begin
						load      = 1'b1;
						ld_last   = word_over && !head_flags.has_close;
						emitted_n = emitted_inc;
					end
					if (word_over) begin
						if (head_flags.has_close) begin
							phase_n = PH_CLOSE;
						end else begin
							pop  = go;
							g3_n = 1'b0;
							s_n  = '0;
						end
					end else if (next_ok) begin
						s_n = s_q + LEN_W'(1);
					end else begin
						g3_n = 1'b1;
						s_n  = '0;
					end
				end
			end
			PH_CLOSE: begin
				load        = 1'b1;
				ld_offset   = '0;
				ld_length   = '0;
				ld_position = clamp16(head_close_words);
				ld_last     = 1'b1;
				ld_done     = 1'b1;
				ld_total    = clamp16(emitted_q);
				emitted_n   = '0;
				pop         = go;
				phase_n     = PH_WORD;
				g3_n        = 1'b0;
				s_n         = '0;
			end
			default: begin
				phase_n = PH_WORD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WORD;
			g3_q        <= 1'b0;
			s_q         <= '0;
			emitted_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				phase_q   <= phase_n;
				g3_q      <= g3_n;
				s_q       <= s_n;
				emitted_q <= emitted_n;
			end
			if (go && load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && load) begin
			out_offset_q   <= ld_offset;
			out_length_q   <= ld_length;
			out_position_q <= ld_position;
			out_last_q     <= ld_last;
			out_done_q     <= ld_done;
			out_total_q    <= ld_total;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_offset   = out_offset_q;
	assign out_length   = out_length_q;
	assign out_position = out_position_q;
	assign out_last     = out_last_q;
	assign out_done     = out_done_q;
	assign out_total    = out_total_q;

	a_close_needs_job: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_CLOSE) |-> head_valid)
		else $error("closing phase without a job at the queue head");

	a_close_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		(go && load && ld_done) |=> (emitted_q == '0))
		else $error("token count not cleared after a closing result");

endmodule

/* src/text_tokenizer_ngram.sv */
// Top level of the byte-stream tokenizer with character n-gram expansion.
// Each result passes through the job queue and then the output register to the master side.
// Throughput: one byte per cycle while the job queue has room; the back end gives one
// result per cycle while the master side is ready, an n-gram word's 2-grams before its 3-grams.
// A word that gives no token, or a text end, still takes its turn in the back end.
// Reset clears all counters and the queue, sets mode 0 and a token limit of 65535.
`timescale 1ns / 1ps

module text_tokenizer_ngram #(
	parameter int MAX_WORD_CHARS = 32,
	parameter int COUNTER_BITS   = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic [tng_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tng_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	// Byte input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,   // byte_value
	input  logic                              s_tlast,   // end of text
	// Result stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// token_offset[15:0], token_length[20:16], word_position[36:21],
	// tokens_total[52:37], zero fill[55:53]
	output logic [tng_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                              m_tuser,   // text_done
	output logic                              m_tlast    // last result of this byte
);
	import tng_pkg::*;

	localparam int LEN_W    = $clog2(MAX_WORD_CHARS);
	localparam int FLAG_W   = $bits(job_flags_t);
	localparam int JOB_W    = FLAG_W + 3 * COUNTER_BITS + LEN_W;
	localparam int QDEPTH   = 4;
	localparam int OUT_USED = 16 + 5 + 16 + 16;

	// Configuration registers. The user must write them only while the block is idle; the
	// block does not enforce this, and both halves read them directly.
	logic [1:0]  mode_q;
	logic [15:0] limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_PUNCT;
			limit_q <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:  mode_q  <= cfg_wdata[1:0];
				REG_LIMIT: limit_q <= cfg_wdata[15:0];
				default: ;
			endcase
		end
	end

	// Front end: one byte per cycle while the job queue has room, a job for every finished word or text end.
	logic                    job_full;
	logic                    job_push;
	job_flags_t              job_flags;
	logic [COUNTER_BITS-1:0] job_start;
	logic [LEN_W-1:0]        job_len;
	logic [COUNTER_BITS-1:0] job_pos;
	logic [COUNTER_BITS-1:0] job_close_words;

	tng_front #(
		.MAX_WORD_CHARS(MAX_WORD_CHARS),
		.COUNTER_BITS  (COUNTER_BITS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.mode           (mode_q),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.in_byte        (s_tdata),
		.in_eot         (s_tlast),
		.job_full       (job_full),
		.job_push       (job_push),
		.job_flags      (job_flags),
		.job_start      (job_start),
		.job_len        (job_len),
		.job_pos        (job_pos),
		.job_close_words(job_close_words)
	);

	// The queue lets the front keep scanning while the back end works through
	// the n-grams of an earlier word.
	logic [JOB_W-1:0]        push_data;
	logic [JOB_W-1:0]        head_data;
	logic                    head_valid;
	logic                    head_pop;
	job_flags_t              head_flags;
	logic [COUNTER_BITS-1:0] head_start;
	logic [LEN_W-1:0]        head_len;
	logic [COUNTER_BITS-1:0] head_pos;
	logic [COUNTER_BITS-1:0] head_close_words;

	assign push_data = {job_flags, job_start, job_len, job_pos, job_close_words};
	assign {head_flags, head_start, head_len, head_pos, head_close_words} = head_data;

	tng_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QDEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (push_data),
		.full      (job_full),
		.pop       (head_pop),
		.head_valid(head_valid),
		.head_data (head_data)
	);

	// Back end: one result per cycle into the output register while the result side is ready.
	logic [15:0] out_offset;
	logic [4:0]  out_length;
	logic [15:0] out_position;
	logic [15:0] out_total;

	tng_back #(
		.MAX_WORD_CHARS(MAX_WORD_CHARS),
		.COUNTER_BITS  (COUNTER_BITS)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.token_limit     (limit_q),
		.head_valid      (head_valid),
		.head_flags      (head_flags),
		.head_start      (head_start),
		.head_len        (head_len),
		.head_pos        (head_pos),
		.head_close_words(head_close_words),
		.pop             (head_pop),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_offset      (out_offset),
		.out_length      (out_length),
		.out_position    (out_position),
		.out_last        (m_tlast),
		.out_done        (m_tuser),
		.out_total       (out_total)
	);

	assign m_tdata = {(OUT_DATA_W - OUT_USED)'(0), out_total, out_position, out_length,
		out_offset};

endmodule

/* tb/tng_token_checker.sv */
// Watches the byte and result streams of the tokenizer, predicts every descriptor and compares.
`timescale 1ns / 1ps

module tng_token_checker #(
	parameter int WORD_CAP = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tng_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tng_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [7:0]                     s_tdata,
	input  logic                           s_tlast,
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [tng_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                           m_tuser,
	input  logic                           m_tlast,
	output int                             pending,
	output int                             fail_count
);
	import tng_pkg::*;

	localparam int COUNT_TOP = 65535;
	localparam int SHOW_LIMIT = 10;

	typedef enum logic [1:0] {BK_TEXT, BK_SPACE, BK_PUNCT} byte_kind_t;

	typedef struct packed {
		logic [15:0] offset;
		logic [4:0]  len;
		logic [15:0] wpos;
		logic [15:0] total;
		logic        done;
		logic        last;
	} token_desc_t;

	// Mirror of the block's registers and scan state.
	logic [1:0]  cur_mode;
	int          tok_limit;
	int          scan_pos;
	int          wstart;
	int          wlen;
	int          wcount;
	int          emitted;
	bit          in_word;
	token_desc_t token_q[$];

	token_desc_t want;
	logic        bad;

	function automatic int bump(input int v);
		return (v >= COUNT_TOP) ? COUNT_TOP : v + 1;
	endfunction

	function automatic byte_kind_t classify(input logic [7:0] b);
		case (b) inside
			CH_NUL, CH_TAB, CH_LF, CH_CR, CH_SPACE: return BK_SPACE;
			CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_BANG, CH_QUEST, CH_LPAREN,
			CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_DQUOTE,
			CH_SQUOTE: return BK_PUNCT;
			default: return BK_TEXT;
		endcase
	endfunction

	task automatic restart_text();
		scan_pos = 0;
		wstart   = 0;
		wlen     = 0;
		in_word  = 1'b0;
		wcount   = 0;
		emitted  = 0;
	endtask

	task automatic add_token(input int off, input int len, input int pos, input bit done,
			input int total);
		token_desc_t d;
		d.offset = 16'((off > COUNT_TOP) ? COUNT_TOP : off);
		d.len    = 5'(len);
		d.wpos   = 16'(pos);
		d.total  = 16'(total);
		d.done   = done;
		d.last   = 1'b0;
		token_q.push_back(d);
	endtask

	// A finished word gives one whole-word token, or its 2-grams then 3-grams, while the token limit allows.
	task automatic close_word();
		if (cur_mode == MODE_NGRAM) begin
			for (int g = 2; g <= 3; g++) begin
				for (int s = 0; s + g <= wlen; s++) begin
					if (emitted < tok_limit) begin
						add_token(wstart + s, g, wcount, 1'b0, 0);
						emitted = bump(emitted);
					end
				end
			end
		end else if (wlen > 0 && emitted < tok_limit) begin
			add_token(wstart, wlen, wcount, 1'b0, 0);
			emitted = bump(emitted);
		end
		wcount  = bump(wcount);
		in_word = 1'b0;
		wlen    = 0;
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic eot);
		byte_kind_t k;
		bit         breaks;
		int         mark;
		k      = classify(b);
		breaks = (k == BK_SPACE) || (k == BK_PUNCT && cur_mode == MODE_PUNCT);
		mark   = token_q.size();
		if (breaks) begin
			if (in_word)
				close_word();
		end else begin
			if (!in_word) begin
				in_word = 1'b1;
				wstart  = scan_pos;
				wlen    = 0;
			end
			wlen++;
			// Overlong words are cut one short of the cap.
			if (wlen >= WORD_CAP - 1)
				close_word();
		end
		scan_pos = bump(scan_pos);
		if (eot) begin
			if (in_word)
				close_word();
			add_token(0, 0, wcount, 1'b1, emitted);
			restart_text();
		end
		if (token_q.size() > mark)
			token_q[token_q.size() - 1].last = 1'b1;
	endtask

	task automatic note_fail(input string what);
		if (fail_count < SHOW_LIMIT)
			$display("%0t: %s", $realtime, what);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_mode  = MODE_PUNCT;
			tok_limit = COUNT_TOP;
			restart_text();
			token_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_MODE)
					cur_mode = cfg_wdata[1:0];
				else if (cfg_index == REG_LIMIT)
					tok_limit = int'(cfg_wdata);
			end
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (token_q.size() == 0) begin
					note_fail($sformatf("result with nothing expected: data %h done %0b last %0b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = token_q.pop_front();
					bad = (m_tdata[15:0] != want.offset) || (m_tdata[20:16] != want.len) ||
						(m_tdata[36:21] != want.wpos) || (m_tdata[52:37] != want.total) ||
						(m_tdata[55:53] != 3'b000) || (m_tuser != want.done) ||
						(m_tlast != want.last);
					if (bad)
						note_fail($sformatf({"result mismatch: got off %0d len %0d pos %0d ",
							"total %0d fill %0h done %0b last %0b, expected off %0d len %0d ",
							"pos %0d total %0d fill 0 done %0b last %0b"},
							m_tdata[15:0], m_tdata[20:16], m_tdata[36:21], m_tdata[52:37],
							m_tdata[55:53], m_tuser, m_tlast, want.offset, want.len,
							want.wpos, want.total, want.done, want.last));
				end
			end
			pending <= token_q.size();
		end
	end

endmodule

/* tb/text_tokenizer_ngram_tb.sv */
// Stimulus and verdict for the tokenizer; the checker beside the block does all prediction.
`timescale 1ns / 1ps

module text_tokenizer_ngram_tb;

	import tng_pkg::*;

	// Mode codes the package leaves unnamed; both split on whitespace only.
	localparam logic [1:0] MODE_SPACE = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// Cycles left for word jobs that give no result before a register write.
	localparam int QUIET_CYCLES = 16;
	localparam int RANDOM_BYTES = 90;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  s_tlast;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	int pending;
	int fail_count;

	// Gap switches for the two sides, changed from phase to phase.
	bit tx_gaps;
	bit rx_gaps;
	// Letters still to come in the word being generated.
	int word_left;

	text_tokenizer_ngram dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	tng_token_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.pending    (pending),
		.fail_count (fail_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard stop in case the block hangs or drops results.
	initial begin
		#20000000;
		$display("status: fail");
		$finish;
	end

	// Result side: ready drops now and then while gaps are on.
	initial begin
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_gaps && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Offers one byte and returns at the edge where the transaction completes.
	task automatic put_byte(input logic [7:0] b, input logic eot);
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eot;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_text(input string txt, input bit eot_at_end);
		for (int i = 0; i < txt.len(); i++)
			put_byte(txt[i], eot_at_end && i == txt.len() - 1);
	endtask

	// Stops the byte stream and waits until every predicted result has been taken.
	// The checker's count is registered, so the task lets the clock run on before it first reads it.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		wait_drained();
		repeat (QUIET_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Text made of words of random letters and high bytes, broken by whitespace and
	// punctuation, with a share of arbitrary bytes as noise. About one word in ten is drawn
	// with 25 to 40 letters, and the longer of these can hit the length cut.
	task automatic pick_byte(output logic [7:0] b);
		logic [7:0] marks[14];
		marks = '{CH_DOT, CH_COMMA, CH_SEMI, CH_COLON, CH_BANG, CH_QUEST, CH_LPAREN,
			CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_LBRACE, CH_RBRACE, CH_DQUOTE, CH_SQUOTE};
		if ($urandom_range(0, 99) < 8) begin
			b = 8'($urandom_range(1, 255));
		end else if (word_left > 0) begin
			word_left--;
			if ($urandom_range(0, 9) == 0)
				b = 8'($urandom_range(8'h80, 8'hFF));
			else
				b = 8'($urandom_range(8'h61, 8'h7A));
		end else begin
			case ($urandom_range(0, 5))
				0: b = CH_SPACE;
				1: b = CH_TAB;
				2: b = CH_LF;
				3: b = CH_CR;
				default: b = marks[$urandom_range(0, 13)];
			endcase
			word_left = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 40) :
				$urandom_range(1, 7);
		end
	endtask

	initial begin
		logic [7:0]  b;
		logic [15:0] lim;
		int          sent_random;
		int          text_len;
		int          hold_at;

		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tlast   <= 1'b0;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		word_left = 0;
		sent_random = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: punctuation and whitespace split, a zero byte acts as a space,
		// 0xFF is a letter, and the text ends inside a word.
		send_text("Ab, c.", 1'b0);
		put_byte(CH_NUL, 1'b0);
		put_byte("d", 1'b0);
		put_byte(8'hFF, 1'b1);

		// N-grams, a one-letter word, then a mode switch in the middle of a word:
		// the word runs on across the switch and ends as a whole-word token.
		set_reg(REG_MODE, 16'(MODE_NGRAM));
		send_text("qrs a mn", 1'b0);
		set_reg(REG_MODE, 16'(MODE_PUNCT));
		put_byte("o", 1'b0);
		put_byte("!", 1'b1);

		// A zero token limit leaves only the closing result; the spare mode code
		// behaves as whitespace only.
		set_reg(REG_LIMIT, 16'd0);
		set_reg(REG_MODE, 16'(MODE_SPARE));
		send_text("a b", 1'b1);

		// The limit cuts the n-gram list of a word short.
		set_reg(REG_LIMIT, 16'd2);
		set_reg(REG_MODE, 16'(MODE_NGRAM));
		send_text("abcd", 1'b1);

		// Random texts, each under fresh settings and fresh gap switches. Some texts
		// pause the byte stream in the middle until all results are in.
		while (sent_random < RANDOM_BYTES) begin
			set_reg(REG_MODE, 16'($urandom_range(0, 3)));
			case ($urandom_range(0, 4))
				0: lim = 16'd1;
				1: lim = 16'($urandom_range(2, 6));
				2: lim = 16'hFFFF;
				default: lim = 16'($urandom_range(0, 65535));
			endcase
			set_reg(REG_LIMIT, lim);
			tx_gaps = $urandom_range(0, 3) != 0;
			rx_gaps = $urandom_range(0, 3) != 0;
			text_len = $urandom_range(6, 45);
			hold_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, text_len - 1) : -1;
			word_left = $urandom_range(1, 6);
			for (int i = 0; i < text_len; i++) begin
				if (i == hold_at)
					wait_drained();
				pick_byte(b);
				put_byte(b, i == text_len - 1);
			end
			sent_random += text_len;
		end

		// Final stretch at full rate: a short n-gram text that ends with an overlong
		// word, whose cut gives the most n-gram tokens that one word can give.
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		set_reg(REG_MODE, 16'(MODE_NGRAM));
		set_reg(REG_LIMIT, 16'hFFFF);
		set_reg(REG_MODE, 16'(MODE_SPACE));
		set_reg(REG_MODE, 16'(MODE_NGRAM));
		send_text("abc ", 1'b0);
		send_text("abcdefghijklmnopqrstuvwxyzABCDEFGHI", 1'b1);

		wait_drained();
		repeat (QUIET_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

/* files.f */
src/tng_pkg.sv
src/tng_front.sv
src/tng_queue.sv
src/tng_back.sv
src/text_tokenizer_ngram.sv
tb/tng_token_checker.sv
tb/text_tokenizer_ngram_tb.sv
